/* src/sn3_pkg.sv */
// SN3 keystream generator: shared constants, state type and word helpers.
// Used by sn3_mix and sn3_keystream_generator_core; no dependencies.
package sn3_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int NUM_WORDS   = 3 * TABLE_DEPTH;
	localparam int ADDR_W      = IDX_W + 2;
	localparam int KEY_MAX     = 64;
	localparam int KADDR_W     = $clog2(KEY_MAX);
	localparam int KLEN_W      = $clog2(KEY_MAX + 1);

	localparam logic [31:0] B_CONST = 32'h8c591ca1;
	localparam logic [31:0] C_CONST = 32'hab8ec254;

	typedef enum logic [1:0] {
		KIND_KEY    = 2'd0,
		KIND_FINISH = 2'd1,
		KIND_REQ    = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL_RD,
		ST_FILL_BYTE,
		ST_RA,
		ST_RB,
		ST_RC,
		ST_WA,
		ST_WB,
		ST_WC,
		ST_MIX_RD,
		ST_MIX_WR
	} state_t;

	typedef struct packed {
		logic [31:0] new_a;
		logic [31:0] new_b;
		logic [31:0] new_c;
		logic [31:0] word;
	} mix_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic logic [1:0] next_role(input logic [1:0] r);
		return (r == 2'd2) ? 2'd0 : r + 2'd1;
	endfunction

endpackage

/* src/sn3_keystream_generator_core.sv */
// SN3 keystream generator top level: table, buffer and key memories plus sequencer.
// Depends on sn3_pkg and sn3_mix.
//
//  channel | signals                      | direction | content
//  in      | in_valid in_ready            | to core   | kind, key_byte
//  out     | out_valid out_ready          | from core | keystream_word
//
// Key byte: stored on acceptance; unused kind: ignored. Request: accepted in idle,
// then three reads and three writes on the table memory (registered read); the
// result is registered to the output with the third write, and no new input is
// taken until the core is idle again. Finish: a word fill from four key reads per
// table word, a setup step per word, then a mix pass over every word. Reset clears
// control state and the table valid bits; invalid entries read as zero. A request
// stalls in its last step while the output register still holds an untaken item.
module sn3_keystream_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  key_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] keystream_word
);

	localparam logic [sn3_pkg::ADDR_W-1:0] LAST_W = sn3_pkg::ADDR_W'(sn3_pkg::NUM_WORDS - 1);

	sn3_pkg::state_t state_q, state_d;

	logic [31:0] seed_mem [sn3_pkg::NUM_WORDS];
	logic [31:0] buf_mem [sn3_pkg::NUM_WORDS];
	logic [7:0]  key_mem [sn3_pkg::KEY_MAX];

	logic [sn3_pkg::NUM_WORDS-1:0] valid_q;
	logic [31:0] seed_rd_q, buf_rd_q, seed_rd;
	logic [7:0]  key_rd_q;
	logic        rvld_q;

	logic                      seed_we, buf_we;
	logic [sn3_pkg::ADDR_W-1:0] seed_ra, seed_wa;
	logic [31:0]               seed_wd;

	logic [sn3_pkg::KLEN_W-1:0]  klen_q;
	logic [sn3_pkg::KADDR_W-1:0] kpos_q;
	logic [1:0]                  lane_q;
	logic [23:0]                 fill_q;
	logic [sn3_pkg::ADDR_W-1:0]  pos_q, wcnt_q;
	logic [sn3_pkg::IDX_W-1:0]   j_q;
	logic [31:0]                 a_q, b_q, c_q;
	logic                        setup_q;
	logic                        out_valid_q;
	logic [31:0]                 out_q;

	logic        accept, wc_go;
	logic [1:0]  role_a, role_b, role_c;
	logic [sn3_pkg::ADDR_W-1:0] addr_a, addr_b, addr_c;
	logic [7:0]  fill_byte;
	sn3_pkg::mix_t mix;

	sn3_mix u_mix (
		.a   (a_q),
		.b   (b_q),
		.c   (c_q),
		.mix (mix)
	);

	assign in_ready       = (state_q == sn3_pkg::ST_IDLE);
	assign accept         = in_valid && in_ready;
	assign out_valid      = out_valid_q;
	assign keystream_word = out_q;

	assign role_a = pos_q[sn3_pkg::ADDR_W-1 -: 2];
	assign role_b = sn3_pkg::next_role(role_a);
	assign role_c = sn3_pkg::next_role(role_b);
	assign addr_a = {role_a, pos_q[sn3_pkg::IDX_W-1:0]};
	assign addr_b = {role_b, j_q};
	assign addr_c = {role_c, a_q[sn3_pkg::IDX_W-1:0]};
	assign seed_rd   = rvld_q ? seed_rd_q : 32'd0;
	assign fill_byte = (klen_q == '0) ? 8'd0 : key_rd_q;
	assign wc_go     = setup_q || !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sn3_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (sn3_pkg::kind_t'(kind))
						sn3_pkg::KIND_FINISH: state_d = sn3_pkg::ST_FILL_RD;
						sn3_pkg::KIND_REQ:    state_d = sn3_pkg::ST_RA;
						default:              state_d = sn3_pkg::ST_IDLE;
					endcase
				end
			end
			sn3_pkg::ST_FILL_RD:   state_d = sn3_pkg::ST_FILL_BYTE;
			sn3_pkg::ST_FILL_BYTE: begin
				if (lane_q == 2'd3 && wcnt_q == LAST_W)
					state_d = sn3_pkg::ST_RA;
				else
					state_d = sn3_pkg::ST_FILL_RD;
			end
			sn3_pkg::ST_RA: state_d = sn3_pkg::ST_RB;
			sn3_pkg::ST_RB: state_d = sn3_pkg::ST_RC;
			sn3_pkg::ST_RC: state_d = sn3_pkg::ST_WA;
			sn3_pkg::ST_WA: state_d = sn3_pkg::ST_WB;
			sn3_pkg::ST_WB: state_d = sn3_pkg::ST_WC;
			sn3_pkg::ST_WC: begin
				if (wc_go) begin
					if (!setup_q)
						state_d = sn3_pkg::ST_IDLE;
					else if (pos_q == LAST_W)
						state_d = sn3_pkg::ST_MIX_RD;
					else
						state_d = sn3_pkg::ST_RA;
				end
			end
			sn3_pkg::ST_MIX_RD: state_d = sn3_pkg::ST_MIX_WR;
			sn3_pkg::ST_MIX_WR: begin
				if (wcnt_q == LAST_W)
					state_d = sn3_pkg::ST_IDLE;
				else
					state_d = sn3_pkg::ST_MIX_RD;
			end
			default: state_d = sn3_pkg::ST_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		seed_we = 1'b0;
		buf_we  = 1'b0;
		seed_ra = addr_a;
		seed_wa = addr_a;
		seed_wd = mix.new_a;
		unique case (state_q)
			sn3_pkg::ST_FILL_BYTE: begin
				seed_we = (lane_q == 2'd3);
				seed_wa = wcnt_q;
				seed_wd = {fill_byte, fill_q};
			end
			sn3_pkg::ST_RB: seed_ra = addr_b;
			sn3_pkg::ST_RC: seed_ra = addr_c;
			sn3_pkg::ST_WA: seed_we = 1'b1;
			sn3_pkg::ST_WB: begin
				seed_we = 1'b1;
				seed_wa = addr_b;
				seed_wd = mix.new_b;
			end
			sn3_pkg::ST_WC: begin
				seed_we = wc_go;
				seed_wa = addr_c;
				seed_wd = mix.new_c;
				buf_we  = wc_go && setup_q;
			end
			sn3_pkg::ST_MIX_RD: seed_ra = wcnt_q;
			sn3_pkg::ST_MIX_WR: begin
				seed_we = 1'b1;
				seed_wa = wcnt_q;
				seed_wd = sn3_pkg::rotl(seed_rd, 19) ^ buf_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (seed_we)
			seed_mem[seed_wa] <= seed_wd;
		seed_rd_q <= seed_mem[seed_ra];
		if (buf_we)
			buf_mem[pos_q] <= mix.word;
		buf_rd_q <= buf_mem[wcnt_q];
		if (accept && sn3_pkg::kind_t'(kind) == sn3_pkg::KIND_KEY
		    && klen_q < sn3_pkg::KLEN_W'(sn3_pkg::KEY_MAX))
			key_mem[klen_q[sn3_pkg::KADDR_W-1:0]] <= key_byte;
		key_rd_q <= key_mem[kpos_q];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			sn3_pkg::ST_RB: a_q <= seed_rd;
			sn3_pkg::ST_RC: b_q <= seed_rd;
			sn3_pkg::ST_WA: c_q <= seed_rd;
			default: ;
		endcase
		if (state_q == sn3_pkg::ST_FILL_BYTE) begin
			unique case (lane_q)
				2'd0: fill_q[7:0]   <= fill_byte;
				2'd1: fill_q[15:8]  <= fill_byte;
				2'd2: fill_q[23:16] <= fill_byte;
				default: ;
			endcase
		end
		if (state_q == sn3_pkg::ST_WC && wc_go && !setup_q)
			out_q <= mix.word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sn3_pkg::ST_IDLE;
			valid_q     <= '0;
			rvld_q      <= 1'b0;
			klen_q      <= '0;
			kpos_q      <= '0;
			lane_q      <= '0;
			pos_q       <= '0;
			wcnt_q      <= '0;
			j_q         <= '0;
			setup_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rvld_q  <= valid_q[seed_ra];
			if (seed_we)
				valid_q[seed_wa] <= 1'b1;
			if (out_ready)
				out_valid_q <= 1'b0;
			if (accept) begin
				unique case (sn3_pkg::kind_t'(kind))
					sn3_pkg::KIND_KEY: begin
						if (klen_q < sn3_pkg::KLEN_W'(sn3_pkg::KEY_MAX))
							klen_q <= klen_q + 1'b1;
					end
					sn3_pkg::KIND_FINISH: begin
						wcnt_q  <= '0;
						lane_q  <= '0;
						kpos_q  <= '0;
						pos_q   <= '0;
						setup_q <= 1'b1;
					end
					sn3_pkg::KIND_REQ: setup_q <= 1'b0;
					default: ;
				endcase
			end
			unique case (state_q)
				sn3_pkg::ST_FILL_BYTE: begin
					lane_q <= lane_q + 2'd1;
					if (klen_q != '0) begin
						if ({1'b0, kpos_q} + 1'b1 >= klen_q)
							kpos_q <= '0;
						else
							kpos_q <= kpos_q + 1'b1;
					end
					if (lane_q == 2'd3)
						wcnt_q <= (wcnt_q == LAST_W) ? '0 : wcnt_q + 1'b1;
				end
				sn3_pkg::ST_WC: begin
					if (wc_go) begin
						j_q   <= a_q[8 +: sn3_pkg::IDX_W];
						pos_q <= (pos_q == LAST_W) ? '0 : pos_q + 1'b1;
						if (!setup_q)
							out_valid_q <= 1'b1;
					end
				end
				sn3_pkg::ST_MIX_WR: begin
					wcnt_q <= wcnt_q + 1'b1;
					if (wcnt_q == LAST_W) begin
						klen_q  <= '0;
						setup_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_req_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind == sn3_pkg::KIND_REQ |=> state_q == sn3_pkg::ST_RA)
		else $error("request did not start a step");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sn3_pkg::ST_WC && !setup_q && out_valid_q && !out_ready
		|=> state_q == sn3_pkg::ST_WC)
		else $error("step finished over an untaken item");
	a_klen_max: assert property (@(posedge clk) disable iff (!arst_n)
		klen_q <= sn3_pkg::KLEN_W'(sn3_pkg::KEY_MAX))
		else $error("key length beyond store");
	a_filled: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sn3_pkg::ST_MIX_RD |-> &valid_q)
		else $error("mix pass with unfilled table");
`endif

endmodule

/* src/sn3_mix.sv */
// SN3 generator step arithmetic: new table words and keystream word.
// Depends on sn3_pkg.
module sn3_mix (
	input  logic [31:0]     a,
	input  logic [31:0]     b,
	input  logic [31:0]     c,
	output sn3_pkg::mix_t   mix
);

	always_comb begin
		mix.new_a = sn3_pkg::rotl(a, 1) ^ b;
		mix.new_b = sn3_pkg::rotl(b, 5) ^ c ^ sn3_pkg::B_CONST;
		mix.new_c = sn3_pkg::rotl(c, 17) ^ a ^ sn3_pkg::C_CONST;
		mix.word  = a ^ b ^ c;
	end

endmodule
